[hdl/tri_pkg.sv]
// Shared definitions for the three-anchor trilateration block.
// Holds default widths, register indexes and result status codes.
// Depends on nothing.
`default_nettype none

package tri_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [2:0] CFG_SETTLE = 3'd4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ANCHOR_A_X = 3'd0,
      REG_ANCHOR_A_Y = 3'd1,
      REG_ANCHOR_B_X = 3'd2,
      REG_ANCHOR_B_Y = 3'd3,
      REG_ANCHOR_C_X = 3'd4,
      REG_ANCHOR_C_Y = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_COLLINEAR    = 2'd1,
      STATUS_NEG_RADICAND = 2'd2
   } status_type;

endpackage

`default_nettype wire

[hdl/tri_div.sv]
// Pipelined restoring divider, one quotient bit per stage, two numerators
// sharing one divisor. Flags quotients that do not fit in QW bits.
// Depends on nothing.
`default_nettype none

module tri_div #(
   parameter int NW  = 104,
   parameter int DNW = 69,
   parameter int QW  = 32,
   parameter int SW  = 50
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           adv,
   input  wire logic           in_valid,
   input  wire logic [NW-1:0]  num_x,
   input  wire logic [NW-1:0]  num_y,
   input  wire logic [DNW-1:0] den,
   input  wire logic [SW-1:0]  side_in,
   output logic                out_valid,
   output logic [QW-1:0]       quo_x,
   output logic [QW-1:0]       quo_y,
   output logic                ovf_x,
   output logic                ovf_y,
   output logic [SW-1:0]       side_out
);

   localparam int IW = ((NW > DNW + QW) ? NW : DNW + QW) + 1;

   logic [QW:0]     valid_ff;
   logic [IW-1:0]   rx_ff [QW+1];
   logic [IW-1:0]   ry_ff [QW+1];
   logic [DNW-1:0]  den_ff [QW+1];
   logic [QW-1:0]   qx_ff [QW+1];
   logic [QW-1:0]   qy_ff [QW+1];
   logic            ox_ff [QW+1];
   logic            oy_ff [QW+1];
   logic [SW-1:0]   side_ff [QW+1];
   logic [IW-1:0]   top_den;

   assign top_den = IW'(den) << QW;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[QW-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rx_ff[0]   <= IW'(num_x);
         ry_ff[0]   <= IW'(num_y);
         den_ff[0]  <= den;
         qx_ff[0]   <= '0;
         qy_ff[0]   <= '0;
         ox_ff[0]   <= (IW'(num_x) >= top_den);
         oy_ff[0]   <= (IW'(num_y) >= top_den);
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 1; k <= QW; k++) begin : g_bit
      localparam int B = QW - k;
      logic [IW-1:0] sub_w;
      logic          take_x;
      logic          take_y;

      assign sub_w  = IW'(den_ff[k-1]) << B;
      assign take_x = (rx_ff[k-1] >= sub_w);
      assign take_y = (ry_ff[k-1] >= sub_w);

      always_ff @(posedge clock) begin
         if (adv) begin
            rx_ff[k]   <= take_x ? rx_ff[k-1] - sub_w : rx_ff[k-1];
            ry_ff[k]   <= take_y ? ry_ff[k-1] - sub_w : ry_ff[k-1];
            qx_ff[k]   <= qx_ff[k-1] | (QW'(take_x) << B);
            qy_ff[k]   <= qy_ff[k-1] | (QW'(take_y) << B);
            den_ff[k]  <= den_ff[k-1];
            ox_ff[k]   <= ox_ff[k-1];
            oy_ff[k]   <= oy_ff[k-1];
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[QW];
   assign quo_x     = qx_ff[QW];
   assign quo_y     = qy_ff[QW];
   assign ovf_x     = ox_ff[QW];
   assign ovf_y     = oy_ff[QW];
   assign side_out  = side_ff[QW];

endmodule

`default_nettype wire

[hdl/tri_sqrt.sv]
// Pipelined integer square root, one root bit per stage, giving the floor
// of the square root of an unsigned radicand. Depends on nothing.
`default_nettype none

module tri_sqrt #(
   parameter int RMW = 64,
   parameter int ZB  = 32,
   parameter int SW  = 65
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           adv,
   input  wire logic           in_valid,
   input  wire logic [RMW-1:0] rad,
   input  wire logic [SW-1:0]  side_in,
   output logic                out_valid,
   output logic [ZB-1:0]       root,
   output logic [SW-1:0]       side_out
);

   localparam int TW = ((RMW > 2 * ZB + 1) ? RMW : 2 * ZB + 1) + 1;

   logic [ZB:0]    valid_ff;
   logic [TW-1:0]  rem_ff [ZB+1];
   logic [ZB-1:0]  root_ff [ZB+1];
   logic [SW-1:0]  side_ff [ZB+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[ZB-1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= TW'(rad);
         root_ff[0] <= '0;
         side_ff[0] <= side_in;
      end
   end

   for (genvar k = 1; k <= ZB; k++) begin : g_bit
      localparam int B = ZB - k;
      logic [TW-1:0] trial;
      logic          take;

      assign trial = (TW'(root_ff[k-1]) << (B + 1)) | (TW'(1) << (2 * B));
      assign take  = (rem_ff[k-1] >= trial);

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= take ? rem_ff[k-1] - trial : rem_ff[k-1];
            root_ff[k] <= root_ff[k-1] | (ZB'(take) << B);
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = valid_ff[ZB];
   assign root      = root_ff[ZB];
   assign side_out  = side_ff[ZB];

endmodule

`default_nettype wire

[hdl/three_anchor_trilateration.sv]
// Top level of the three-anchor trilateration block.
// Depends on tri_pkg, tri_div and tri_sqrt.
//
// Usage: write the six anchor coordinates through the csr_ channel (index 0..5:
// a_x, a_y, b_x, b_y, c_x, c_y; other indexes are ignored). After reset or a write
// the req_ channel holds req_tready low while the anchor-derived terms settle,
// until a settle counter loaded with CFG_SETTLE runs down. Each req_ item carries
// range_sq_a, range_sq_b, range_sq_c and gives exactly one rsp_ item with pos_x,
// pos_y, pos_z and the status in rsp_tuser.
// Throughput is one item per cycle while rsp_tready does not stall the output
// and no settle wait is pending. The divider and the square root resolve one
// bit per stage. All stages advance together whenever the output register is
// empty or taken, so a stall on rsp_tready freezes the pipeline and drops
// req_tready in the same cycle; nothing is lost or repeated. Reset clears the
// anchors to zero and empties the pipeline.
`default_nettype none

module three_anchor_trilateration
   import tri_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire logic                                        csr_valid,
   output logic                                             csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0]                  csr_index,
   input  wire logic [COORD_WIDTH-1:0]                      csr_data,
   input  wire logic                                        req_tvalid,
   output logic                                             req_tready,
   // range_sq_a, range_sq_b, range_sq_c
   input  wire logic [((3*(COORD_WIDTH+FRAC_BITS)+7)/8)*8-1:0] req_tdata,
   output logic                                             rsp_tvalid,
   input  wire logic                                        rsp_tready,
   // pos_x, pos_y, pos_z
   output logic [((3*COORD_WIDTH+7)/8)*8-1:0]                rsp_tdata,
   // status
   output logic [1:0]                                       rsp_tuser
);

   localparam int CW   = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int RW   = CW + F;
   localparam int DW   = CW + 1;
   localparam int PW   = 2 * DW + 1;
   localparam int SQW  = 2 * CW;
   localparam int KW   = SQW + 2;
   localparam int EA   = RW + 1 + F;
   localparam int EW   = ((EA > KW) ? EA : KW) + 1;
   localparam int H    = (EW + 1) / 2;
   localparam int EHW  = EW - H;
   localparam int PLW  = DW + H + 1;
   localparam int PHW  = DW + EHW;
   localparam int QLW  = PLW + 1;
   localparam int QHW  = PHW + 1;
   localparam int NW   = DW + EW + 2;
   localparam int MW   = PW + 1;
   localparam int DNW  = MW + 1;
   localparam int NNW  = ((NW + 1 > MW) ? NW + 1 : MW) + 1;
   localparam int RMW  = CW + 2 * F;
   localparam int ZB   = (RMW + 1) / 2;
   localparam int ZBX  = (ZB > CW) ? ZB : CW;
   localparam int RADW = ((RMW > 2 * DW) ? RMW : 2 * DW) + 2;
   localparam int OTW  = ((3 * CW + 7) / 8) * 8;
   localparam int DSW  = RW + 2;
   localparam int SSW  = 2 * CW + 1;

   function automatic logic [CW-1:0] sat_q(input logic [CW-1:0] q, input logic o,
                                           input logic s);
      logic [CW-1:0] maxp;
      logic [CW-1:0] minn;
      maxp = {1'b0, {(CW-1){1'b1}}};
      minn = {1'b1, {(CW-1){1'b0}}};
      if (!s) begin
         sat_q = (o || q[CW-1]) ? maxp : q;
      end else begin
         sat_q = (o || (q > minn)) ? minn : CW'(-q);
      end
   endfunction

   // Configuration and anchor-derived terms
   logic signed [CW-1:0]  ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [2:0]            cfg_wait_ff;
   logic signed [DW-1:0]  da_ff, db_ff, dc_ff, dd_ff;
   logic signed [SQW-1:0] sqax_ff, sqay_ff, sqbx_ff, sqby_ff, sqcx_ff, sqcy_ff;
   logic signed [2*DW-1:0] ad_ff, bc_ff;
   logic signed [KW-1:0]  s1_ff, s2_ff, s3_ff;
   logic signed [PW-1:0]  p_ff;
   logic signed [KW-1:0]  k2_ff, k3_ff;
   logic [MW-1:0]         m_ff;
   logic [DNW-1:0]        den_ff;
   logic                  p_neg_ff, p_zero_ff;
   logic                  adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ax_ff       <= '0;
         ay_ff       <= '0;
         bx_ff       <= '0;
         by_ff       <= '0;
         cx_ff       <= '0;
         cy_ff       <= '0;
         cfg_wait_ff <= CFG_SETTLE;
      end else begin
         if (csr_valid) begin
            cfg_wait_ff <= CFG_SETTLE;
            unique case (csr_index)
               REG_ANCHOR_A_X: ax_ff <= $signed(csr_data);
               REG_ANCHOR_A_Y: ay_ff <= $signed(csr_data);
               REG_ANCHOR_B_X: bx_ff <= $signed(csr_data);
               REG_ANCHOR_B_Y: by_ff <= $signed(csr_data);
               REG_ANCHOR_C_X: cx_ff <= $signed(csr_data);
               REG_ANCHOR_C_Y: cy_ff <= $signed(csr_data);
               default: ;
            endcase
         end else if (cfg_wait_ff != 3'd0) begin
            cfg_wait_ff <= cfg_wait_ff - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      da_ff   <= DW'(ax_ff) - DW'(bx_ff);
      db_ff   <= DW'(ay_ff) - DW'(by_ff);
      dc_ff   <= DW'(ax_ff) - DW'(cx_ff);
      dd_ff   <= DW'(ay_ff) - DW'(cy_ff);
      sqax_ff <= ax_ff * ax_ff;
      sqay_ff <= ay_ff * ay_ff;
      sqbx_ff <= bx_ff * bx_ff;
      sqby_ff <= by_ff * by_ff;
      sqcx_ff <= cx_ff * cx_ff;
      sqcy_ff <= cy_ff * cy_ff;

      ad_ff   <= da_ff * dd_ff;
      bc_ff   <= db_ff * dc_ff;
      s1_ff   <= KW'(sqax_ff) + KW'(sqay_ff);
      s2_ff   <= KW'(sqbx_ff) + KW'(sqby_ff);
      s3_ff   <= KW'(sqcx_ff) + KW'(sqcy_ff);

      p_ff    <= PW'(ad_ff) - PW'(bc_ff);
      k2_ff   <= s1_ff - s2_ff;
      k3_ff   <= s1_ff - s3_ff;

      m_ff      <= MW'(p_ff[PW-1] ? PW'(-p_ff) : PW'(p_ff)) << 1;
      den_ff    <= DNW'(p_ff[PW-1] ? PW'(-p_ff) : PW'(p_ff)) << 2;
      p_neg_ff  <= p_ff[PW-1];
      p_zero_ff <= (p_ff == '0);
   end

   // Item pipeline ahead of the divider
   logic                  out_vld_ff;
   logic [6:0]            pre_vld_ff;
   logic [RW-1:0]         r1_ff, r2_ff, r3_ff;
   logic [RW-1:0]         l1_s2_ff, l1_s3_ff, l1_s4_ff, l1_s5_ff, l1_s6_ff, l1_s7_ff;
   logic signed [EW-1:0]  e2_ff, e3_ff;
   logic signed [H:0]     e2lo_w, e3lo_w;
   logic signed [EHW-1:0] e2hi_w, e3hi_w;
   logic signed [PLW-1:0] pdl2_ff, pbl3_ff, pal3_ff, pcl2_ff;
   logic signed [PHW-1:0] pdh2_ff, pbh3_ff, pah3_ff, pch2_ff;
   logic signed [QLW-1:0] qlo_ff, rlo_ff;
   logic signed [QHW-1:0] qhi_ff, rhi_ff;
   logic signed [NW-1:0]  qn_ff, rn_ff;
   logic [NW-1:0]         nx_ff, ny_ff;
   logic                  sx_s6_ff, sy_s6_ff;
   logic [NNW-1:0]        numx_ff, numy_ff;
   logic                  sx_s7_ff, sy_s7_ff;

   assign adv        = !out_vld_ff || rsp_tready;
   assign req_tready = adv && (cfg_wait_ff == 3'd0);

   assign e2lo_w = $signed({1'b0, e2_ff[H-1:0]});
   assign e3lo_w = $signed({1'b0, e3_ff[H-1:0]});
   assign e2hi_w = e2_ff[EW-1:H];
   assign e3hi_w = e3_ff[EW-1:H];

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= '0;
      end else if (adv) begin
         pre_vld_ff <= {pre_vld_ff[5:0], req_tvalid && req_tready};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r1_ff    <= req_tdata[RW-1:0];
         r2_ff    <= req_tdata[2*RW-1:RW];
         r3_ff    <= req_tdata[3*RW-1:2*RW];

         e2_ff    <= ((EW'($signed({1'b0, r2_ff})) - EW'($signed({1'b0, r1_ff}))) << F)
                     + EW'(k2_ff);
         e3_ff    <= ((EW'($signed({1'b0, r3_ff})) - EW'($signed({1'b0, r1_ff}))) << F)
                     + EW'(k3_ff);
         l1_s2_ff <= r1_ff;

         pdl2_ff  <= dd_ff * e2lo_w;
         pdh2_ff  <= dd_ff * e2hi_w;
         pbl3_ff  <= db_ff * e3lo_w;
         pbh3_ff  <= db_ff * e3hi_w;
         pal3_ff  <= da_ff * e3lo_w;
         pah3_ff  <= da_ff * e3hi_w;
         pcl2_ff  <= dc_ff * e2lo_w;
         pch2_ff  <= dc_ff * e2hi_w;
         l1_s3_ff <= l1_s2_ff;

         qlo_ff   <= QLW'(pdl2_ff) - QLW'(pbl3_ff);
         qhi_ff   <= QHW'(pdh2_ff) - QHW'(pbh3_ff);
         rlo_ff   <= QLW'(pal3_ff) - QLW'(pcl2_ff);
         rhi_ff   <= QHW'(pah3_ff) - QHW'(pch2_ff);
         l1_s4_ff <= l1_s3_ff;

         qn_ff    <= (NW'(qhi_ff) << H) + NW'(qlo_ff);
         rn_ff    <= (NW'(rhi_ff) << H) + NW'(rlo_ff);
         l1_s5_ff <= l1_s4_ff;

         nx_ff    <= qn_ff[NW-1] ? NW'(-qn_ff) : NW'(qn_ff);
         ny_ff    <= rn_ff[NW-1] ? NW'(-rn_ff) : NW'(rn_ff);
         sx_s6_ff <= qn_ff[NW-1] ^ p_neg_ff;
         sy_s6_ff <= rn_ff[NW-1] ^ p_neg_ff;
         l1_s6_ff <= l1_s5_ff;

         numx_ff  <= (NNW'(nx_ff) << 1) + NNW'(m_ff);
         numy_ff  <= (NNW'(ny_ff) << 1) + NNW'(m_ff);
         sx_s7_ff <= sx_s6_ff;
         sy_s7_ff <= sy_s6_ff;
         l1_s7_ff <= l1_s6_ff;
      end
   end

   // Rounded quotients x = Q / 2P and y = R / 2P
   logic           div_vld;
   logic [CW-1:0]  quo_x, quo_y;
   logic           ovf_x, ovf_y;
   logic [DSW-1:0] div_side;

   tri_div #(
      .NW  (NNW),
      .DNW (DNW),
      .QW  (CW),
      .SW  (DSW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (pre_vld_ff[6]),
      .num_x     (numx_ff),
      .num_y     (numy_ff),
      .den       (den_ff),
      .side_in   ({l1_s7_ff, sx_s7_ff, sy_s7_ff}),
      .out_valid (div_vld),
      .quo_x     (quo_x),
      .quo_y     (quo_y),
      .ovf_x     (ovf_x),
      .ovf_y     (ovf_y),
      .side_out  (div_side)
   );

   // Height from the planar offset
   logic [3:0]              post_vld_ff;
   logic signed [CW-1:0]    x_s8_ff, y_s8_ff, x_s9_ff, y_s9_ff, x_s10_ff, y_s10_ff;
   logic signed [CW-1:0]    x_s11_ff, y_s11_ff;
   logic [RW-1:0]           l1_s8_ff, l1_s9_ff, l1_s10_ff;
   logic signed [DW-1:0]    dx_ff, dy_ff;
   logic signed [2*DW-1:0]  sqx_ff, sqy_ff;
   logic [RADW-1:0]         rad_w;
   logic [RMW-1:0]          rmag_ff;
   logic                    neg_s11_ff;

   assign rad_w = (RADW'(l1_s10_ff) << F) - RADW'(sqx_ff) - RADW'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= '0;
      end else if (adv) begin
         post_vld_ff <= {post_vld_ff[2:0], div_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_s8_ff    <= sat_q(quo_x, ovf_x, div_side[1]);
         y_s8_ff    <= sat_q(quo_y, ovf_y, div_side[0]);
         l1_s8_ff   <= div_side[DSW-1:2];

         dx_ff      <= DW'(x_s8_ff) - DW'(ax_ff);
         dy_ff      <= DW'(y_s8_ff) - DW'(ay_ff);
         x_s9_ff    <= x_s8_ff;
         y_s9_ff    <= y_s8_ff;
         l1_s9_ff   <= l1_s8_ff;

         sqx_ff     <= dx_ff * dx_ff;
         sqy_ff     <= dy_ff * dy_ff;
         x_s10_ff   <= x_s9_ff;
         y_s10_ff   <= y_s9_ff;
         l1_s10_ff  <= l1_s9_ff;

         neg_s11_ff <= rad_w[RADW-1];
         rmag_ff    <= rad_w[RADW-1] ? '0 : rad_w[RMW-1:0];
         x_s11_ff   <= x_s10_ff;
         y_s11_ff   <= y_s10_ff;
      end
   end

   logic           sqrt_vld;
   logic [ZB-1:0]  root;
   logic [SSW-1:0] sqrt_side;

   tri_sqrt #(
      .RMW (RMW),
      .ZB  (ZB),
      .SW  (SSW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (post_vld_ff[3]),
      .rad       (rmag_ff),
      .side_in   ({x_s11_ff, y_s11_ff, neg_s11_ff}),
      .out_valid (sqrt_vld),
      .root      (root),
      .side_out  (sqrt_side)
   );

   // Output register
   logic [CW-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [1:0]    status_ff;
   logic [CW-1:0] z_w;
   logic          neg_w;

   assign neg_w = sqrt_side[0];
   assign z_w   = (ZBX'(root) > ZBX'({CW{1'b1}})) ? '1 : CW'(root);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= sqrt_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         if (p_zero_ff) begin
            pos_x_ff  <= '0;
            pos_y_ff  <= '0;
            pos_z_ff  <= '0;
            status_ff <= STATUS_COLLINEAR;
         end else begin
            pos_x_ff  <= sqrt_side[SSW-1:CW+1];
            pos_y_ff  <= sqrt_side[CW:1];
            pos_z_ff  <= neg_w ? '0 : z_w;
            status_ff <= neg_w ? STATUS_NEG_RADICAND : STATUS_OK;
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = OTW'({pos_z_ff, pos_y_ff, pos_x_ff});
   assign rsp_tuser  = status_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_COLLINEAR |-> rsp_tdata == '0)
      else $error("collinear result carries a nonzero position");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_NEG_RADICAND |-> pos_z_ff == '0)
      else $error("negative radicand result carries a nonzero height");

   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |=> !req_tready)
      else $error("item taken before anchor terms settled");

endmodule

`default_nettype wire

[dv/tb_three_anchor_trilateration.sv]
// Self-checking testbench for the three-anchor trilateration block.
// Writes anchor sets over the csr_ channel, streams squared distances, and checks
// every result against a wide-integer solver of its own. Needs tri_pkg and the RTL.
`timescale 1ns / 1ps

module tb_three_anchor_trilateration
   import tri_pkg::*;
();

   typedef logic signed [255:0] wide_type;
   typedef struct {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      status_type  st;
   } position_type;
   typedef struct {
      bit           at_reset;
      logic [47:0]  ra;
      logic [47:0]  rb;
      logic [47:0]  rc;
      bit           typed;
      position_type want;
   } stim_row_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 120;
   localparam int RANDOM_ITEMS = 1800;
   localparam int NUM_SETS = 9;
   localparam logic [47:0] RMAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] UNIT = 32'h0001_0000;
   localparam position_type NO_POS = '{32'd0, 32'd0, 32'd0, STATUS_OK};

   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [95:0] rsp_tdata;
   logic [1:0] rsp_tuser;

   logic signed [31:0] anchors [6];
   position_type pending_positions [$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int status_count [3];
   bit idle_on = 1;
   bit long_hold = 0;
   int quiet_cycles = 0;

   three_anchor_trilateration uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic wide_type round_quotient(wide_type n, wide_type m);
      wide_type na, ma, q;
      na = (n < 0) ? -n : n;
      ma = (m < 0) ? -m : m;
      q = (2 * na + ma) / (2 * ma);
      return ((n < 0) != (m < 0)) ? -q : q;
   endfunction

   function automatic wide_type clamp_coord(wide_type v);
      wide_type hi, lo;
      hi = (wide_type'(1) <<< 31) - 1;
      lo = -(wide_type'(1) <<< 31);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   function automatic position_type solve_position(logic [47:0] ra, logic [47:0] rb,
                                                   logic [47:0] rc);
      position_type res;
      wide_type x1, y1, x2, y2, x3, y3, l1, l2, l3, a, b, c, d, p;
      wide_type s1, e2, e3, qn, rn, x, y, rad, cw;
      logic [63:0] root, cand;
      x1 = anchors[0]; y1 = anchors[1];
      x2 = anchors[2]; y2 = anchors[3];
      x3 = anchors[4]; y3 = anchors[5];
      l1 = {208'd0, ra}; l2 = {208'd0, rb}; l3 = {208'd0, rc};
      a = x1 - x2; b = y1 - y2; c = x1 - x3; d = y1 - y3;
      p = a * d - b * c;
      if (p == 0) begin
         res.x = 0; res.y = 0; res.z = 0; res.st = STATUS_COLLINEAR;
         return res;
      end
      s1 = x1 * x1 + y1 * y1;
      e2 = ((l2 - l1) <<< 16) + s1 - (x2 * x2 + y2 * y2);
      e3 = ((l3 - l1) <<< 16) + s1 - (x3 * x3 + y3 * y3);
      qn = d * e2 - b * e3;
      rn = a * e3 - c * e2;
      x = clamp_coord(round_quotient(qn, 2 * p));
      y = clamp_coord(round_quotient(rn, 2 * p));
      rad = (l1 <<< 16) - ((x - x1) * (x - x1) + (y - y1) * (y - y1));
      res.x = x[31:0];
      res.y = y[31:0];
      if (rad < 0) begin
         res.z = 0;
         res.st = STATUS_NEG_RADICAND;
      end else begin
         root = 0;
         for (int i = 63; i >= 0; i--) begin
            cand = root | (64'd1 << i);
            cw = {192'd0, cand};
            if (cw * cw <= rad) root = cand;
         end
         res.z = (root > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : root[31:0];
         res.st = STATUS_OK;
      end
      return res;
   endfunction

   function automatic logic [47:0] range_to(int k, wide_type px, wide_type py,
                                            wide_type pz);
      wide_type dx, dy, t;
      dx = px - wide_type'(anchors[2 * k]);
      dy = py - wide_type'(anchors[2 * k + 1]);
      t = (dx * dx + dy * dy + pz * pz) >>> 16;
      if (t > wide_type'(RMAX)) t = wide_type'(RMAX);
      return t[47:0];
   endfunction

   // The caller drops csr_valid after its last write.
   task automatic write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [31:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx <= REG_ANCHOR_C_Y) anchors[idx] = val;
      @(negedge clock);
   endtask

   task automatic send_ranges(logic [47:0] ra, logic [47:0] rb, logic [47:0] rc,
                              bit typed, position_type want);
      while (idle_on && $urandom_range(99) < 34) begin
         req_tvalid <= 0;
         @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {rc, rb, ra};
      do @(posedge clock); while (!req_tready);
      pending_positions.push_back(typed ? want : solve_position(ra, rb, rc));
      items_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (pending_positions.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_item();
      wide_type px, py, pz;
      logic [47:0] r [3];
      if ($urandom_range(99) < 70) begin
         px = wide_type'($signed(anchors[$urandom_range(2) * 2]))
              + $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
         py = wide_type'($signed(anchors[$urandom_range(2) * 2 + 1]))
              + $signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000;
         pz = $urandom_range(3) == 0 ? 0 : $urandom_range(32'h00FF_FFFF);
         for (int k = 0; k < 3; k++) begin
            r[k] = range_to(k, px, py, pz);
            if ($urandom_range(3) == 0) r[k] = r[k] + $urandom_range(4095) - 2048;
         end
      end else begin
         for (int k = 0; k < 3; k++) begin
            case ($urandom_range(5))
               0: r[k] = 0;
               1: r[k] = RMAX;
               2: r[k] = $urandom_range(32'hFFFF_FFFF);
               default: r[k] = 48'({$urandom, $urandom});
            endcase
         end
      end
      send_ranges(r[0], r[1], r[2], 0, NO_POS);
   endtask

   stim_row_type directed_rows [] = '{
      '{1, 48'd0, 48'd0, 48'd0, 1, '{32'd0, 32'd0, 32'd0, STATUS_COLLINEAR}},
      '{1, RMAX, RMAX, RMAX, 1, '{32'd0, 32'd0, 32'd0, STATUS_COLLINEAR}},
      '{1, RMAX, 48'd0, RMAX, 1, '{32'd0, 32'd0, 32'd0, STATUS_COLLINEAR}},
      '{1, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'd1, 1,
        '{32'd0, 32'd0, 32'd0, STATUS_COLLINEAR}},
      '{0, 48'd1638400, 48'd4259840, 48'd2949120, 0, NO_POS},
      '{0, 48'd0, 48'd6553600, 48'd6553600, 0, NO_POS},
      '{0, 48'd0, 48'h8000_0000_0000, 48'h8000_0000_0000, 0, NO_POS},
      '{0, 48'd0, 48'd0, 48'd0, 0, NO_POS},
      '{0, RMAX, RMAX, RMAX, 0, NO_POS},
      '{0, RMAX, 48'd0, 48'd0, 0, NO_POS},
      '{0, 48'd0, RMAX, 48'd0, 0, NO_POS},
      '{0, 48'd0, 48'd0, RMAX, 0, NO_POS},
      '{0, 48'd3276800, 48'd3276800, 48'd3276800, 0, NO_POS},
      '{0, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 48'hFFFF_0000_FFFF, 0, NO_POS}
   };

   logic [31:0] anchor_sets [NUM_SETS][6];

   initial begin
      int per_set;
      anchor_sets[0] = '{32'd0, 32'd0, 10 * UNIT, 32'd0, 32'd0, 10 * UNIT};
      anchor_sets[1] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                         32'h7FFF_FFFF, 32'h7FFF_FFFF};
      anchor_sets[2] = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0000, 32'h7FFF_FFFF};
      anchor_sets[3] = '{UNIT, UNIT, 2 * UNIT, 2 * UNIT, 5 * UNIT, 5 * UNIT};
      anchor_sets[4] = '{32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE, 32'd3, 32'd2, 32'hFFFF_FFFD};
      for (int s = 5; s < NUM_SETS; s++) begin
         for (int k = 0; k < 6; k++) begin
            anchor_sets[s][k] = (s == NUM_SETS - 1) ? $urandom
                              : $urandom_range(32'h003F_FFFF) - 32'h0020_0000;
         end
      end
      for (int k = 0; k < 6; k++) anchors[k] = 0;
      per_set = RANDOM_ITEMS / NUM_SETS;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].at_reset) begin
            send_ranges(directed_rows[i].ra, directed_rows[i].rb, directed_rows[i].rc,
                        directed_rows[i].typed, directed_rows[i].want);
         end
      end

      for (int s = 0; s < NUM_SETS; s++) begin
         wait_drained();
         for (int k = 0; k <= REG_ANCHOR_C_Y; k++) begin
            write_reg(reg_index_type'(k), anchor_sets[s][k]);
         end
         write_reg(CSR_INDEX_WIDTH'(REG_ANCHOR_C_Y + 1 + $urandom_range(1)), $urandom);
         csr_valid <= 0;
         if (s == 0) begin
            foreach (directed_rows[i]) begin
               if (!directed_rows[i].at_reset) begin
                  send_ranges(directed_rows[i].ra, directed_rows[i].rb, directed_rows[i].rc,
                              0, directed_rows[i].want);
               end
            end
         end
         idle_on = (s != 4);
         if (s == 2) long_hold = 1;
         for (int n = 0; n < per_set; n++) begin
            if (s == 6 && n == per_set / 2) begin
               req_tvalid <= 0;
               while (pending_positions.size() != 0) @(negedge clock);
            end
            send_random_item();
         end
         idle_on = 1;
      end

      req_tvalid <= 0;
      while (pending_positions.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d items over %0d anchor sets plus reset anchors.",
               items_sent, NUM_SETS);
      $display("Results: %0d ok, %0d collinear, %0d negative radicand.",
               status_count[0], status_count[1], status_count[2]);
      if (errors == 0 && pending_positions.size() == 0) begin
         $display("three_anchor_trilateration: match");
      end else begin
         $display("three_anchor_trilateration: mismatch");
      end
      $finish;
   end

   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            long_hold = 0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= !(idle_on && $urandom_range(99) < 34);
         end
      end
   end

   always @(posedge clock) begin
      position_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser < 3) status_count[rsp_tuser]++;
         if (pending_positions.size() == 0) begin
            $error("unexpected result x=%h y=%h z=%h status=%0d",
                   rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser);
            errors++;
         end else begin
            want = pending_positions.pop_front();
            if (rsp_tdata[31:0] !== want.x) begin
               $error("pos_x expected %h actual %h", want.x, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want.y) begin
               $error("pos_y expected %h actual %h", want.y, rsp_tdata[63:32]);
               errors++;
            end
            if (rsp_tdata[95:64] !== want.z) begin
               $error("pos_z expected %h actual %h", want.z, rsp_tdata[95:64]);
               errors++;
            end
            if (rsp_tuser !== want.st) begin
               $error("status expected %0d actual %0d", want.st, rsp_tuser);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d results outstanding.",
                  pending_positions.size());
         $display("three_anchor_trilateration: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
